/* rtl/ppucri_pkg.sv */
package ppucri_pkg;

  localparam int OAM_BYTES_DEFAULT = 256;

  // item kinds
  localparam logic [1:0] FUNC_READ   = 2'd0;
  localparam logic [1:0] FUNC_WRITE  = 2'd1;
  localparam logic [1:0] FUNC_STATUS = 2'd2;
  localparam logic [1:0] FUNC_NOP    = 2'd3;

  // register indexes
  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  localparam logic [13:0] PALETTE_BASE = 14'h3F00;
  localparam logic [15:0] STEP_ROW     = 16'd32;
  localparam logic [15:0] STEP_ONE     = 16'd1;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        read_supported;
    logic        vram_write;
    logic [15:0] vram_write_addr;
    logic [7:0]  vram_write_data;
    logic [15:0] video_addr;
    logic [14:0] temp_addr;
    logic [2:0]  fine_x;
    logic [7:0]  control_reg;
    logic [7:0]  mask_reg;
    logic [7:0]  scroll_x;
    logic [7:0]  scroll_y;
  } res_t;

  typedef struct packed {
    logic       rd;
    logic       we;
    logic [7:0] addr;
    logic [7:0] wdata;
  } oam_req_t;

endpackage

/* rtl/ppucri_oam.sv */
module ppucri_oam #(
  parameter int OAM_BYTES = ppucri_pkg::OAM_BYTES_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ppucri_pkg::oam_req_t    req,
  output logic [7:0]              rdata
);

  localparam int AW = $clog2(OAM_BYTES);

  logic [7:0]           mem [OAM_BYTES];
  logic [OAM_BYTES-1:0] written;
  logic [7:0]           q;
  logic                 q_ok;
  logic [AW-1:0]        idx;

  assign idx = req.addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[idx] <= req.wdata;
    end
    if (req.rd) begin
      q <= mem[idx];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      q_ok    <= 1'b0;
    end else begin
      if (req.we) begin
        written[idx] <= 1'b1;
      end
      if (req.rd) begin
        q_ok <= written[idx];
      end
    end
  end

  assign rdata = q_ok ? q : 8'h00;

endmodule

/* rtl/ppucri_regs.sv */
module ppucri_regs (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [1:0]           func,
  input  logic [2:0]           reg_select,
  input  logic [7:0]           data,
  input  logic [7:0]           vram_read_data,
  output ppucri_pkg::res_t     res,
  output ppucri_pkg::oam_req_t oam_req
);

  logic [7:0]  control_byte, control_byte_next;
  logic [7:0]  mask_byte, mask_byte_next;
  logic [7:0]  oam_pointer, oam_pointer_next;
  logic [14:0] temp_address, temp_address_next;
  logic [15:0] video_address, video_address_next;
  logic [2:0]  fine_scroll_x, fine_scroll_x_next;
  logic [7:0]  scroll_x_byte, scroll_x_byte_next;
  logic [7:0]  scroll_y_byte, scroll_y_byte_next;
  logic        write_toggle, write_toggle_next;
  logic [7:0]  read_buffer, read_buffer_next;
  logic [2:0]  status_flags, status_flags_next;
  logic [15:0] video_step;
  logic        below_palette;

  assign video_step    = control_byte[2] ? ppucri_pkg::STEP_ROW : ppucri_pkg::STEP_ONE;
  assign below_palette = video_address[13:0] < ppucri_pkg::PALETTE_BASE;

  always_comb begin
    control_byte_next  = control_byte;
    mask_byte_next     = mask_byte;
    oam_pointer_next   = oam_pointer;
    temp_address_next  = temp_address;
    video_address_next = video_address;
    fine_scroll_x_next = fine_scroll_x;
    scroll_x_byte_next = scroll_x_byte;
    scroll_y_byte_next = scroll_y_byte;
    write_toggle_next  = write_toggle;
    read_buffer_next   = read_buffer;
    status_flags_next  = status_flags;
    res                = '0;
    oam_req            = '0;
    oam_req.addr       = oam_pointer;
    oam_req.wdata      = data;

    unique case (func)
      ppucri_pkg::FUNC_READ: begin
        unique case (reg_select)
          ppucri_pkg::REG_STATUS: begin
            res.read_data      = {status_flags, read_buffer[4:0]};
            res.read_supported = 1'b1;
            status_flags_next  = {1'b0, status_flags[1:0]};
            write_toggle_next  = 1'b0;
          end
          ppucri_pkg::REG_OAM_DATA: begin
            // data arrives from the registered oam read port in the cycle after the access
            res.read_supported = 1'b1;
            oam_req.rd         = 1'b1;
          end
          ppucri_pkg::REG_DATA: begin
            if (below_palette) begin
              res.read_data    = read_buffer;
              read_buffer_next = vram_read_data;
            end else begin
              res.read_data = vram_read_data;
            end
            res.read_supported = 1'b1;
            video_address_next = video_address + video_step;
          end
          default: ;
        endcase
      end
      ppucri_pkg::FUNC_WRITE: begin
        unique case (reg_select)
          ppucri_pkg::REG_CTRL: begin
            control_byte_next = data;
            temp_address_next = {temp_address[14:12], data[1:0], temp_address[9:0]};
          end
          ppucri_pkg::REG_MASK: begin
            mask_byte_next = data;
          end
          ppucri_pkg::REG_OAM_ADDR: begin
            oam_pointer_next = data;
          end
          ppucri_pkg::REG_OAM_DATA: begin
            oam_req.we       = 1'b1;
            oam_pointer_next = oam_pointer + 8'd1;
          end
          ppucri_pkg::REG_SCROLL: begin
            if (!write_toggle) begin
              scroll_x_byte_next = data;
              fine_scroll_x_next = data[2:0];
              temp_address_next  = {temp_address[14:5], data[7:3]};
              write_toggle_next  = 1'b1;
            end else begin
              scroll_y_byte_next = data;
              temp_address_next  = {data[2:0], temp_address[11:10], data[7:3],
                                    temp_address[4:0]};
              write_toggle_next  = 1'b0;
            end
          end
          ppucri_pkg::REG_ADDR: begin
            if (!write_toggle) begin
              temp_address_next = {1'b0, data[5:0], temp_address[7:0]};
              write_toggle_next = 1'b1;
            end else begin
              temp_address_next  = {temp_address[14:8], data};
              video_address_next = {1'b0, temp_address[14:8], data};
              write_toggle_next  = 1'b0;
            end
          end
          ppucri_pkg::REG_DATA: begin
            res.vram_write      = 1'b1;
            res.vram_write_addr = video_address;
            res.vram_write_data = data;
            video_address_next  = video_address + video_step;
          end
          default: ;
        endcase
      end
      ppucri_pkg::FUNC_STATUS: begin
        status_flags_next = data[7:5];
      end
      default: ;
    endcase

    if (!accept) begin
      oam_req.rd = 1'b0;
      oam_req.we = 1'b0;
    end

    res.video_addr  = video_address_next;
    res.temp_addr   = temp_address_next;
    res.fine_x      = fine_scroll_x_next;
    res.control_reg = control_byte_next;
    res.mask_reg    = mask_byte_next;
    res.scroll_x    = scroll_x_byte_next;
    res.scroll_y    = scroll_y_byte_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_byte  <= '0;
      mask_byte     <= '0;
      oam_pointer   <= '0;
      temp_address  <= '0;
      video_address <= '0;
      fine_scroll_x <= '0;
      scroll_x_byte <= '0;
      scroll_y_byte <= '0;
      write_toggle  <= 1'b0;
      read_buffer   <= '0;
      status_flags  <= '0;
    end else if (accept) begin
      control_byte  <= control_byte_next;
      mask_byte     <= mask_byte_next;
      oam_pointer   <= oam_pointer_next;
      temp_address  <= temp_address_next;
      video_address <= video_address_next;
      fine_scroll_x <= fine_scroll_x_next;
      scroll_x_byte <= scroll_x_byte_next;
      scroll_y_byte <= scroll_y_byte_next;
      write_toggle  <= write_toggle_next;
      read_buffer   <= read_buffer_next;
      status_flags  <= status_flags_next;
    end
  end

endmodule

/* rtl/ppu_cpu_register_interface.sv */
// CPU-side register port of a 2C02-style PPU: one bus access (read, write) or
// status-flag load from the renderer per transaction, one result per
// transaction. A new transaction is taken every cycle unless in_stall is raised;
// each result is registered in stage s1 and then in the output register, the
// extra register stage covering the registered read port of the 256-byte OAM.
// The OAM reads as zero after reset until written, with no clearing pass. A
// stalled output holds one result while one more transaction may still enter
// behind it.
module ppu_cpu_register_interface #(
  parameter int OAM_BYTES = ppucri_pkg::OAM_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [2:0]  reg_select,
  input  logic [7:0]  data,
  input  logic [7:0]  vram_read_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic        read_supported,
  output logic        vram_write,
  output logic [15:0] vram_write_addr,
  output logic [7:0]  vram_write_data,
  output logic [15:0] video_addr,
  output logic [14:0] temp_addr,
  output logic [2:0]  fine_x,
  output logic [7:0]  control_reg,
  output logic [7:0]  mask_reg,
  output logic [7:0]  scroll_x,
  output logic [7:0]  scroll_y
);

  logic                 accept;
  logic                 s1_valid;
  logic                 s1_oam;
  logic                 s1_adv;
  ppucri_pkg::res_t     s1_res;
  ppucri_pkg::res_t     s1_fwd;
  ppucri_pkg::res_t     item_res;
  ppucri_pkg::res_t     out_res;
  ppucri_pkg::oam_req_t oam_req;
  logic [7:0]           oam_rdata;

  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;

  ppucri_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .func           (func),
    .reg_select     (reg_select),
    .data           (data),
    .vram_read_data (vram_read_data),
    .res            (item_res),
    .oam_req        (oam_req)
  );

  ppucri_oam #(
    .OAM_BYTES (OAM_BYTES)
  ) u_oam (
    .clk   (clk),
    .rst   (rst),
    .req   (oam_req),
    .rdata (oam_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_comb begin
    s1_fwd = s1_res;
    // oam data transaction: byte comes from the memory read port
    if (s1_oam) begin
      s1_fwd.read_data = oam_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res <= item_res;
      s1_oam <= oam_req.rd;
    end
    if (s1_adv && s1_valid) begin
      out_res <= s1_fwd;
    end
  end

  assign read_data       = out_res.read_data;
  assign read_supported  = out_res.read_supported;
  assign vram_write      = out_res.vram_write;
  assign vram_write_addr = out_res.vram_write_addr;
  assign vram_write_data = out_res.vram_write_data;
  assign video_addr      = out_res.video_addr;
  assign temp_addr       = out_res.temp_addr;
  assign fine_x          = out_res.fine_x;
  assign control_reg     = out_res.control_reg;
  assign mask_reg        = out_res.mask_reg;
  assign scroll_x        = out_res.scroll_x;
  assign scroll_y        = out_res.scroll_y;

endmodule

/* rtl/ppucri_checker.sv */
module ppucri_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  read_data,
  input logic        read_supported,
  input logic        vram_write,
  input logic [15:0] vram_write_addr,
  input logic [7:0]  vram_write_data
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(vram_write_addr))
    else $error("stalled result changed");

  // a transaction is never both a supported read and a video memory write
  a_rd_wr_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(vram_write && read_supported))
    else $error("read and video write in one result");

  a_rd_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !read_supported |-> read_data == 8'h00)
    else $error("read data without a supported read");

  a_wr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !vram_write |-> vram_write_addr == 16'h0000 && vram_write_data == 8'h00)
    else $error("video write fields set without a write");

endmodule

bind ppu_cpu_register_interface ppucri_checker u_ppucri_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .read_data       (read_data),
  .read_supported  (read_supported),
  .vram_write      (vram_write),
  .vram_write_addr (vram_write_addr),
  .vram_write_data (vram_write_data)
);
